FILE: hdl/lsps_pkg.sv
// Shared constants, register codes, types and sequencer states for the line sensor steering block.
`timescale 1ns / 1ps

package lsps_pkg;

  // Sample, fraction and gain widths
  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 12;
  localparam int GAIN_BITS   = 12;

  // Register and result field widths
  localparam int BASE_W  = 14;
  localparam int GAIN_W  = 12;
  localparam int LEVEL_W = 12;
  localparam int MAXS_W  = 8;
  localparam int DRIVE_W = 8;
  localparam int FLAG_W  = 8;

  // Position error datapath widths
  localparam int NUM_W = SAMPLE_BITS + 4;
  localparam int MAG_W = SAMPLE_BITS + 3;
  localparam int DEN_W = SAMPLE_BITS + 3;
  localparam int QUO_W = FRAC_BITS + 2;
  localparam int DVD_W = MAG_W + FRAC_BITS;
  localparam int ERR_W = FRAC_BITS + 3;
  localparam int CHG_W = ERR_W + 1;
  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

  // Drive datapath widths
  localparam int S_W    = ((FRAC_BITS + 4 > BASE_W) ? FRAC_BITS + 4 : BASE_W) + GAIN_BITS + 2;
  localparam int MB_W   = GAIN_W + 1;
  localparam int P_W    = S_W + MB_W;
  localparam int HUND_W = P_W - FRAC_BITS - GAIN_BITS;

  localparam logic signed [MB_W-1:0]  HUNDRED   = MB_W'(100);
  localparam logic signed [ERR_W-1:0] ERR_LIMIT = ERR_W'(3 << FRAC_BITS);

  // APB port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = ADDR_W - 2;

  // Register reset values
  localparam logic [BASE_W-1:0]  BASE_SPEED_RST = BASE_W'(6144);
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = GAIN_W'(860);
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = GAIN_W'(0);
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST  = LEVEL_W'(3000);
  localparam logic [LEVEL_W-1:0] RED_LOW_RST    = LEVEL_W'(500);
  localparam logic [LEVEL_W-1:0] RED_HIGH_RST   = LEVEL_W'(2500);
  localparam logic [MAXS_W-1:0]  MAX_SPEED_RST  = MAXS_W'(200);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE_SPEED,
    REG_PROP_GAIN,
    REG_DERIV_GAIN,
    REG_LINE_THRESHOLD,
    REG_RED_LOW,
    REG_RED_HIGH,
    REG_MAX_SPEED
  } lsps_reg_e;

  typedef struct packed {
    logic [BASE_W-1:0]  base_speed;
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LEVEL_W-1:0] line_threshold;
    logic [LEVEL_W-1:0] red_low;
    logic [LEVEL_W-1:0] red_high;
    logic [MAXS_W-1:0]  max_speed;
  } lsps_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_R,
    ST_MUL_L,
    ST_DONE
  } lsps_state_e;

endpackage

FILE: hdl/lsps_if.sv
// Valid/ready channel interfaces for sensor frames and steering results.
`timescale 1ns / 1ps

interface lsps_in_if import lsps_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] far_right;
  logic [SAMPLE_BITS-1:0] near_right;
  logic [SAMPLE_BITS-1:0] center;
  logic [SAMPLE_BITS-1:0] near_left;
  logic [SAMPLE_BITS-1:0] far_left;
  logic [SAMPLE_BITS-1:0] mid_right;
  logic [SAMPLE_BITS-1:0] mid_left;

  modport source (
    output valid, far_right, near_right, center, near_left, far_left, mid_right, mid_left,
    input  ready
  );
  modport sink (
    input  valid, far_right, near_right, center, near_left, far_left, mid_right, mid_left,
    output ready
  );
endinterface

interface lsps_out_if import lsps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DRIVE_W-1:0]      right_drive;
  logic [DRIVE_W-1:0]      left_drive;
  logic signed [ERR_W-1:0] position_error;
  logic [FLAG_W-1:0]       line_flags;
  logic                    no_signal;

  modport source (
    output valid, right_drive, left_drive, position_error, line_flags, no_signal,
    input  ready
  );
  modport sink (
    input  valid, right_drive, left_drive, position_error, line_flags, no_signal,
    output ready
  );
endinterface

FILE: hdl/lsps_cfg.sv
// APB configuration register bank for the steering block.
`timescale 1ns / 1ps

module lsps_cfg import lsps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output lsps_cfg_t         cfg_o
);

  lsps_cfg_t cfg_q, cfg_d;
  lsps_reg_e reg_idx;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = lsps_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;

  // Decode the write transaction
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_BASE_SPEED:     cfg_d.base_speed     = pwdata[BASE_W-1:0];
        REG_PROP_GAIN:      cfg_d.prop_gain      = pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:     cfg_d.deriv_gain     = pwdata[GAIN_W-1:0];
        REG_LINE_THRESHOLD: cfg_d.line_threshold = pwdata[LEVEL_W-1:0];
        REG_RED_LOW:        cfg_d.red_low        = pwdata[LEVEL_W-1:0];
        REG_RED_HIGH:       cfg_d.red_high       = pwdata[LEVEL_W-1:0];
        REG_MAX_SPEED:      cfg_d.max_speed      = pwdata[MAXS_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_speed     <= BASE_SPEED_RST;
      cfg_q.prop_gain      <= PROP_GAIN_RST;
      cfg_q.deriv_gain     <= DERIV_GAIN_RST;
      cfg_q.line_threshold <= THRESHOLD_RST;
      cfg_q.red_low        <= RED_LOW_RST;
      cfg_q.red_high       <= RED_HIGH_RST;
      cfg_q.max_speed      <= MAX_SPEED_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Return the addressed register on reads
  always_comb begin
    case (reg_idx)
      REG_BASE_SPEED:     prdata = DATA_W'(cfg_q.base_speed);
      REG_PROP_GAIN:      prdata = DATA_W'(cfg_q.prop_gain);
      REG_DERIV_GAIN:     prdata = DATA_W'(cfg_q.deriv_gain);
      REG_LINE_THRESHOLD: prdata = DATA_W'(cfg_q.line_threshold);
      REG_RED_LOW:        prdata = DATA_W'(cfg_q.red_low);
      REG_RED_HIGH:       prdata = DATA_W'(cfg_q.red_high);
      REG_MAX_SPEED:      prdata = DATA_W'(cfg_q.max_speed);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/lsps_div.sv
// Restoring divider, one quotient bit per cycle, for the position error.
`timescale 1ns / 1ps

module lsps_div import lsps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quotient_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      // The quotient is known to fit in QUO_W bits, so the top bits start as remainder
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W);
      rem_d  = DEN_W'(dividend_i[DVD_W-1:QUO_W]);
      quo_d  = dividend_i[QUO_W-1:0];
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hdl/lsps_mul.sv
// Shared signed multiplier used for both gain terms and the hundredths scaling.
`timescale 1ns / 1ps

module lsps_mul import lsps_pkg::*; (
  input  logic signed [S_W-1:0]  a_i,
  input  logic signed [MB_W-1:0] b_i,
  output logic signed [P_W-1:0]  p_o
);

  // Extend both operands to the product width, then multiply
  logic signed [P_W-1:0] a_ext;
  logic signed [P_W-1:0] b_ext;

  assign a_ext = {{(P_W-S_W){a_i[S_W-1]}}, a_i};
  assign b_ext = {{(P_W-MB_W){b_i[MB_W-1]}}, b_i};
  assign p_o   = a_ext * b_ext;

endmodule

FILE: hdl/line_sensor_pd_steering_top.sv
// Top level of the line sensor steering block: sequencer, shared datapath and result register.
//
// Usage: one sensor frame (seven unsigned samples) enters on in_ch, a valid/ready channel;
// a transaction completes at a rising edge with valid and ready high. Each frame gives one
// result on out_ch: right and left drive in hundredths, the Q2.12 position error, eight
// line flags and a no-signal flag for a zero front sum.
// Flow: the restoring divider makes one quotient bit per cycle, then the shared multiplier
// makes four passes: proportional term, derivative term, right drive scaling, left drive
// scaling. A new frame is taken only after the last result has left the sequencer;
// in_ch.ready is high only while the sequencer idles. A finished result sits in the output
// register; the next frame is taken while it waits, and if the receiver stalls, the
// following result holds in the sequencer until out_ch frees. The user must write registers
// over the APB port only while no frame is in flight; the block does not enforce this.
// Reset: registers return to their defaults, the stored previous error clears to zero,
// the output register empties and the sequencer idles. No clearing pass is needed.
`timescale 1ns / 1ps

module line_sensor_pd_steering_top import lsps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lsps_in_if.sink           in_ch,
  lsps_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  lsps_cfg_t   cfg;
  lsps_state_e state_q, state_d;

  logic                    in_acc;
  logic                    out_load;
  logic                    div_done;
  logic [QUO_W-1:0]        quotient;
  logic signed [NUM_W-1:0] num;
  logic [MAG_W-1:0]        num_mag;
  logic [DEN_W-1:0]        den;
  logic [FLAG_W-1:0]       flags;

  logic signed [S_W-1:0]  mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  prod;
  logic signed [S_W-1:0]  base_sh;

  logic signed [ERR_W-1:0] err_next;
  logic signed [CHG_W-1:0] chg_next;

  logic                    neg_q, nosig_q;
  logic [FLAG_W-1:0]       flags_q;
  logic signed [ERR_W-1:0] err_q, prev_q;
  logic signed [CHG_W-1:0] chg_q;
  logic signed [S_W-1:0]   acc_q;
  logic [DRIVE_W-1:0]      right_q, left_q;

  logic                    out_valid_q;
  logic [DRIVE_W-1:0]      out_right_q, out_left_q;
  logic signed [ERR_W-1:0] out_err_q;
  logic [FLAG_W-1:0]       out_flags_q;
  logic                    out_nosig_q;

  // Scale to hundredths, floor, clamp to 0..max
  function automatic logic [DRIVE_W-1:0] to_drive(input logic signed [P_W-1:0] p,
                                                   input logic [MAXS_W-1:0] maxs);
    logic [HUND_W-1:0] hund;
    hund = p[P_W-1:FRAC_BITS+GAIN_BITS];
    if (p[P_W-1]) begin
      to_drive = '0;
    end else if (hund > HUND_W'(maxs)) begin
      to_drive = DRIVE_W'(maxs);
    end else begin
      to_drive = DRIVE_W'(hund);
    end
  endfunction

  lsps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Weighted front sum and plain front sum
  always_comb begin
    logic [NUM_W-1:0] pos_sum;
    logic [NUM_W-1:0] neg_sum;
    pos_sum = (NUM_W'(in_ch.far_left) << 1) + NUM_W'(in_ch.far_left) + NUM_W'(in_ch.near_left);
    neg_sum = (NUM_W'(in_ch.far_right) << 1) + NUM_W'(in_ch.far_right)
              + NUM_W'(in_ch.near_right);
    num     = $signed(pos_sum - neg_sum);
    num_mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    den     = DEN_W'(in_ch.far_right) + DEN_W'(in_ch.near_right) + DEN_W'(in_ch.center)
              + DEN_W'(in_ch.near_left) + DEN_W'(in_ch.far_left);
  end

  // Line detection flags
  always_comb begin
    logic [CMP_W-1:0] thr, rlo, rhi, fr, nr, c, nl, fl, mr, ml;
    thr = CMP_W'(cfg.line_threshold);
    rlo = CMP_W'(cfg.red_low);
    rhi = CMP_W'(cfg.red_high);
    fr  = CMP_W'(in_ch.far_right);
    nr  = CMP_W'(in_ch.near_right);
    c   = CMP_W'(in_ch.center);
    nl  = CMP_W'(in_ch.near_left);
    fl  = CMP_W'(in_ch.far_left);
    mr  = CMP_W'(in_ch.mid_right);
    ml  = CMP_W'(in_ch.mid_left);
    flags[0] = (fr >= thr) && (fl >= thr);
    flags[1] = (mr >= thr) && (ml >= thr);
    flags[2] = (c >= thr) && (mr >= thr) && (ml >= thr);
    flags[3] = (fr >= thr) || (nr >= thr) || (c >= thr) || (nl >= thr) || (fl >= thr);
    flags[4] = (mr >= thr);
    flags[5] = (ml >= thr);
    flags[6] = (c >= thr);
    flags[7] = (mr >= rlo) && (mr <= rhi) && (ml >= rlo) && (ml <= rhi);
  end

  lsps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i ({num_mag, {FRAC_BITS{1'b0}}}),
    .divisor_i  (den),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Signed error from the quotient, and its change against the last frame
  always_comb begin
    logic signed [ERR_W-1:0] q_ext;
    q_ext = $signed(ERR_W'(quotient));
    if (nosig_q) begin
      err_next = '0;
    end else if (neg_q) begin
      err_next = -q_ext;
    end else begin
      err_next = q_ext;
    end
    chg_next = {err_next[ERR_W-1], err_next} - {prev_q[ERR_W-1], prev_q};
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_MUL_P;
      ST_MUL_P: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_MUL_R;
      ST_MUL_R: state_d = ST_MUL_L;
      ST_MUL_L: state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign base_sh = $signed(S_W'({cfg.base_speed, {GAIN_BITS{1'b0}}}));

  // Sequencer: outputs and multiplier operand selection
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    case (state_q)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_MUL_P: begin
        mul_a = {{(S_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        mul_b = $signed({1'b0, cfg.prop_gain});
      end
      ST_MUL_D: begin
        mul_a = {{(S_W-CHG_W){chg_q[CHG_W-1]}}, chg_q};
        mul_b = $signed({1'b0, cfg.deriv_gain});
      end
      ST_MUL_R: begin
        mul_a = base_sh + acc_q;
        mul_b = HUNDRED;
      end
      ST_MUL_L: begin
        mul_a = base_sh - acc_q;
        mul_b = HUNDRED;
      end
      ST_DONE:  out_load = !out_valid_q || out_ch.ready;
      default:  in_ch.ready = 1'b0;
    endcase
  end

  assign in_acc = in_ch.valid && in_ch.ready;

  lsps_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  // Control state and stored previous error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV && div_done) begin
        prev_q <= err_next;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      neg_q   <= num[NUM_W-1];
      nosig_q <= (den == '0);
      flags_q <= flags;
    end
    if (state_q == ST_DIV && div_done) begin
      err_q <= err_next;
      chg_q <= chg_next;
    end
    if (state_q == ST_MUL_P) acc_q <= prod[S_W-1:0];
    if (state_q == ST_MUL_D) acc_q <= acc_q + prod[S_W-1:0];
    if (state_q == ST_MUL_R) right_q <= to_drive(prod, cfg.max_speed);
    if (state_q == ST_MUL_L) left_q <= to_drive(prod, cfg.max_speed);
    if (out_load) begin
      out_right_q <= right_q;
      out_left_q  <= left_q;
      out_err_q   <= err_q;
      out_flags_q <= flags_q;
      out_nosig_q <= nosig_q;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.right_drive    = out_right_q;
  assign out_ch.left_drive     = out_left_q;
  assign out_ch.position_error = out_err_q;
  assign out_ch.line_flags     = out_flags_q;
  assign out_ch.no_signal      = out_nosig_q;

  // An accepted frame starts the divider run
  a_acc_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_DIV)
    else $error("accepted frame did not enter the divide phase");

  // The divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  // A zero front sum reports zero error
  a_nosig_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.no_signal |-> out_ch.position_error == '0)
    else $error("no-signal result with nonzero error");

  // Drives never exceed the ceiling
  a_drive_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.right_drive <= cfg.max_speed
                     && out_ch.left_drive <= cfg.max_speed)
    else $error("drive above ceiling");

  // Error stays within three sensor pitches
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.position_error <= ERR_LIMIT
                     && out_ch.position_error >= -ERR_LIMIT)
    else $error("position error out of range");

endmodule

FILE: tb/sv/lsps_steering_checker.sv
// Checker for the line sensor steering block: mirrors registers, predicts and compares results.
`timescale 1ns / 1ps

module lsps_steering_checker import lsps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lsps_in_if                in_mon,
  lsps_out_if               out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o,
  output int                no_signal_seen_o,
  output int                saturated_seen_o
);

  // Bit positions in line_flags
  localparam int FLAG_FRONT  = 0;
  localparam int FLAG_MIDDLE = 1;
  localparam int FLAG_CROSS  = 2;
  localparam int FLAG_FIND   = 3;
  localparam int FLAG_RIGHT  = 4;
  localparam int FLAG_LEFT   = 5;
  localparam int FLAG_SPIN   = 6;
  localparam int FLAG_RED    = 7;

  typedef struct {
    logic [DRIVE_W-1:0]      right_drive;
    logic [DRIVE_W-1:0]      left_drive;
    logic signed [ERR_W-1:0] position_error;
    logic [FLAG_W-1:0]       line_flags;
    logic                    no_signal;
    bit                      saturated;
  } steer_expect_t;

  lsps_cfg_t     cfg;
  longint        last_error;
  steer_expect_t steer_q[$];
  int            fail_count = 0;
  int            reported = 0;
  int            checked = 0;
  int            pending = 0;
  int            no_signal_seen = 0;
  int            saturated_seen = 0;

  assign fail_count_o     = fail_count;
  assign pending_o        = pending;
  assign checked_o        = checked;
  assign no_signal_seen_o = no_signal_seen;
  assign saturated_seen_o = saturated_seen;

  // Scale a Q.(FRAC+GAIN) drive to hundredths, floor it and clamp to 0..max_speed
  function automatic longint to_hundredths(input longint s, output bit clipped);
    longint h;
    clipped = 1'b0;
    if (s < 0) begin
      clipped = 1'b1;
      return 0;
    end
    h = (s * 100) >>> (FRAC_BITS + GAIN_BITS);
    if (h > longint'(cfg.max_speed)) begin
      clipped = 1'b1;
      h = longint'(cfg.max_speed);
    end
    return h;
  endfunction

  // Work out the steering result of one frame under the current settings
  function automatic steer_expect_t predict_steering(input longint fr, nr, c, nl, fl, mr, ml);
    steer_expect_t x;
    longint num, den, e, change, pd, base, thr, lo, hi;
    bit clip_r, clip_l;
    thr  = cfg.line_threshold;
    lo   = cfg.red_low;
    hi   = cfg.red_high;
    base = longint'(cfg.base_speed) * (longint'(1) << GAIN_BITS);
    num  = 3 * fl + nl - nr - 3 * fr;
    den  = fr + nr + c + nl + fl;
    x.no_signal = (den == 0);
    // Signed division truncates toward zero
    e = x.no_signal ? 0 : (num * (longint'(1) << FRAC_BITS)) / den;
    change = e - last_error;
    pd = e * longint'(cfg.prop_gain) + change * longint'(cfg.deriv_gain);
    x.right_drive    = DRIVE_W'(to_hundredths(base + pd, clip_r));
    x.left_drive     = DRIVE_W'(to_hundredths(base - pd, clip_l));
    x.saturated      = clip_r || clip_l;
    x.position_error = ERR_W'(e);
    x.line_flags              = '0;
    x.line_flags[FLAG_FRONT]  = (fr >= thr) && (fl >= thr);
    x.line_flags[FLAG_MIDDLE] = (mr >= thr) && (ml >= thr);
    x.line_flags[FLAG_CROSS]  = (c >= thr) && (mr >= thr) && (ml >= thr);
    x.line_flags[FLAG_FIND]   = (fr >= thr) || (nr >= thr) || (c >= thr) ||
                                (nl >= thr) || (fl >= thr);
    x.line_flags[FLAG_RIGHT]  = (mr >= thr);
    x.line_flags[FLAG_LEFT]   = (ml >= thr);
    x.line_flags[FLAG_SPIN]   = (c >= thr);
    // An inverted band is empty
    x.line_flags[FLAG_RED]    = (mr >= lo) && (mr <= hi) && (ml >= lo) && (ml <= hi);
    return x;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    steer_expect_t x;
    if (!rst_ni) begin
      cfg = '{BASE_SPEED_RST, PROP_GAIN_RST, DERIV_GAIN_RST, THRESHOLD_RST,
              RED_LOW_RST, RED_HIGH_RST, MAX_SPEED_RST};
      last_error = 0;
      steer_q.delete();
      pending = 0;
    end else begin
      // Mirror register writes
      if (psel && penable && pwrite && pready) begin
        case (lsps_reg_e'(paddr[ADDR_W-1:2]))
          REG_BASE_SPEED:     cfg.base_speed     = pwdata[BASE_W-1:0];
          REG_PROP_GAIN:      cfg.prop_gain      = pwdata[GAIN_W-1:0];
          REG_DERIV_GAIN:     cfg.deriv_gain     = pwdata[GAIN_W-1:0];
          REG_LINE_THRESHOLD: cfg.line_threshold = pwdata[LEVEL_W-1:0];
          REG_RED_LOW:        cfg.red_low        = pwdata[LEVEL_W-1:0];
          REG_RED_HIGH:       cfg.red_high       = pwdata[LEVEL_W-1:0];
          REG_MAX_SPEED:      cfg.max_speed      = pwdata[MAXS_W-1:0];
          default: ;
        endcase
      end
      // Compare a result transaction with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (steer_q.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: steering result with no frame waiting: right %0d left %0d",
                     $time, out_mon.right_drive, out_mon.left_drive);
          end
        end else begin
          x = steer_q.pop_front();
          checked++;
          if (x.right_drive !== out_mon.right_drive || x.left_drive !== out_mon.left_drive ||
              x.position_error !== out_mon.position_error ||
              x.line_flags !== out_mon.line_flags || x.no_signal !== out_mon.no_signal) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: steering mismatch, expected right %0d left %0d error %0d",
                       $time, x.right_drive, x.left_drive, x.position_error,
                       " flags %02h nosig %0b", x.line_flags, x.no_signal);
              $display("%0t:                    got      right %0d left %0d error %0d",
                       $time, out_mon.right_drive, out_mon.left_drive,
                       out_mon.position_error,
                       " flags %02h nosig %0b", out_mon.line_flags, out_mon.no_signal);
            end
          end
        end
      end
      // Predict the result of each frame transaction
      if (in_mon.valid && in_mon.ready) begin
        x = predict_steering(in_mon.far_right, in_mon.near_right, in_mon.center,
                             in_mon.near_left, in_mon.far_left, in_mon.mid_right,
                             in_mon.mid_left);
        last_error = x.position_error;
        if (x.no_signal) no_signal_seen++;
        if (x.saturated) saturated_seen++;
        steer_q.push_back(x);
      end
      pending = steer_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_line_sensor_pd_steering_top.sv
// Testbench top for the line sensor steering block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_line_sensor_pd_steering_top;
  import lsps_pkg::*;

  localparam int QUIET_LIMIT        = 4000;
  localparam int FRAMES_PER_SETTING = 80;
  localparam int RANDOM_SETTINGS    = 5;
  localparam int DRAIN_CYCLES       = 40;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t far_right;
    sample_t near_right;
    sample_t center;
    sample_t near_left;
    sample_t far_left;
    sample_t mid_right;
    sample_t mid_left;
  } frame_t;

  localparam sample_t   FULL      = '1;
  localparam lsps_cfg_t RESET_CFG = '{BASE_SPEED_RST, PROP_GAIN_RST, DERIV_GAIN_RST,
                                      THRESHOLD_RST, RED_LOW_RST, RED_HIGH_RST,
                                      MAX_SPEED_RST};

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int        fail_count;
  int        pending;
  int        checked;
  int        no_signal_seen;
  int        saturated_seen;
  int        frames_sent = 0;
  int        settings_used = 1;
  bit        idle_on;
  lsps_cfg_t cur_cfg;

  lsps_in_if  in_ch ();
  lsps_out_if out_ch ();

  line_sensor_pd_steering_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lsps_steering_checker steer_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .no_signal_seen_o (no_signal_seen),
    .saturated_seen_o (saturated_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_ch.ready <= idle_on ? ($urandom_range(99, 0) >= 31) : 1'b1;
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction in %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending);
    $display("tb_line_sensor_pd_steering_top failed");
    $finish;
  end

  function automatic sample_t rnd_sample();
    return SAMPLE_BITS'($urandom);
  endfunction

  // Pick a level within a couple of counts of the given one
  function automatic sample_t near_level(sample_t level);
    int v;
    v = int'(level) + int'($urandom_range(4, 0)) - 2;
    if (v < 0) v = 0;
    if (v > int'(FULL)) v = int'(FULL);
    return SAMPLE_BITS'(v);
  endfunction

  // Middle sensor sample at the band edges or inside the band, or anywhere for an inverted band
  function automatic sample_t red_sample();
    case ($urandom_range(3, 0))
      0: return near_level(cur_cfg.red_low);
      1: return near_level(cur_cfg.red_high);
      default: begin
        if (cur_cfg.red_low <= cur_cfg.red_high)
          return SAMPLE_BITS'($urandom_range(int'(cur_cfg.red_high), int'(cur_cfg.red_low)));
        return rnd_sample();
      end
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int mode;
    mode = $urandom_range(99, 0);
    f.far_right  = rnd_sample();
    f.near_right = rnd_sample();
    f.center     = rnd_sample();
    f.near_left  = rnd_sample();
    f.far_left   = rnd_sample();
    f.mid_right  = rnd_sample();
    f.mid_left   = rnd_sample();
    if (mode < 10) begin
      // Zero front sum
      f.far_right  = '0;
      f.near_right = '0;
      f.center     = '0;
      f.near_left  = '0;
      f.far_left   = '0;
    end else if (mode < 35) begin
      // Hover around the line threshold
      f.far_right  = near_level(cur_cfg.line_threshold);
      f.near_right = near_level(cur_cfg.line_threshold);
      f.center     = near_level(cur_cfg.line_threshold);
      f.near_left  = near_level(cur_cfg.line_threshold);
      f.far_left   = near_level(cur_cfg.line_threshold);
      f.mid_right  = near_level(cur_cfg.line_threshold);
      f.mid_left   = near_level(cur_cfg.line_threshold);
    end else if (mode < 50) begin
      f.mid_right = red_sample();
      f.mid_left  = red_sample();
    end else if (mode < 62) begin
      // One front sensor carries the whole signal
      f.far_right  = '0;
      f.near_right = '0;
      f.center     = '0;
      f.near_left  = '0;
      f.far_left   = '0;
      case ($urandom_range(4, 0))
        0: f.far_right  = rnd_sample();
        1: f.near_right = rnd_sample();
        2: f.center     = rnd_sample();
        3: f.near_left  = rnd_sample();
        default: f.far_left = rnd_sample();
      endcase
    end
    return f;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(int bits);
    int r;
    r = $urandom_range(99, 0);
    if (r < 15) return '0;
    if (r < 30) return (DATA_W'(1) << bits) - 1;
    return DATA_W'($urandom_range((1 << bits) - 1, 0));
  endfunction

  // Present one frame, idling first at random, and hold it until the transaction
  task automatic send_frame(frame_t f);
    while (idle_on && $urandom_range(99, 0) < 31) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.far_right  <= f.far_right;
    in_ch.near_right <= f.near_right;
    in_ch.center     <= f.center;
    in_ch.near_left  <= f.near_left;
    in_ch.far_left   <= f.far_left;
    in_ch.mid_right  <= f.mid_right;
    in_ch.mid_left   <= f.mid_left;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    frames_sent++;
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Write all registers, back to back, through setup and access cycles
  task automatic write_config(lsps_cfg_t c);
    logic [DATA_W-1:0] value [0:REG_MAX_SPEED];
    value[REG_BASE_SPEED]     = DATA_W'(c.base_speed);
    value[REG_PROP_GAIN]      = DATA_W'(c.prop_gain);
    value[REG_DERIV_GAIN]     = DATA_W'(c.deriv_gain);
    value[REG_LINE_THRESHOLD] = DATA_W'(c.line_threshold);
    value[REG_RED_LOW]        = DATA_W'(c.red_low);
    value[REG_RED_HIGH]       = DATA_W'(c.red_high);
    value[REG_MAX_SPEED]      = DATA_W'(c.max_speed);
    cur_cfg = c;
    for (int i = 0; i <= REG_MAX_SPEED; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(i * 4);
      pwdata  <= value[i];
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      @(negedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  initial begin
    lsps_cfg_t c;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.far_right  = '0;
    in_ch.near_right = '0;
    in_ch.center     = '0;
    in_ch.near_left  = '0;
    in_ch.far_left   = '0;
    in_ch.mid_right  = '0;
    in_ch.mid_left   = '0;
    out_ch.ready     = 1'b0;
    idle_on          = 1'b1;
    cur_cfg          = RESET_CFG;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames under reset settings: extremes, threshold and band edges
    send_frame(frame_t'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0});
    send_frame(frame_t'{FULL, FULL, FULL, FULL, FULL, FULL, FULL});
    send_frame(frame_t'{12'd0, 12'd0, 12'd0, 12'd0, FULL, 12'd0, 12'd0});
    send_frame(frame_t'{FULL, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0});
    send_frame(frame_t'{12'd0, 12'd0, 12'd0, 12'd1, 12'd0, 12'd0, 12'd0});
    send_frame(frame_t'{12'd0, FULL, 12'd0, 12'd0, 12'd0, 12'd500, 12'd2500});
    send_frame(frame_t'{12'd0, 12'd0, 12'd3000, 12'd0, 12'd0, 12'd3000, 12'd3000});
    send_frame(frame_t'{12'd1, 12'd0, 12'd2999, 12'd0, 12'd0, 12'd2999, 12'd499});
    send_frame(frame_t'{12'd3000, 12'd0, 12'd0, 12'd0, 12'd3000, 12'd2501, 12'd2500});
    send_frame(frame_t'{12'd1, 12'd2, 12'd3, 12'd5, FULL, 12'd0, FULL});
    send_frame(frame_t'{FULL, 12'd0, 12'd7, 12'd7, 12'd0, 12'd1, 12'd1});
    send_frame(frame_t'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0});

    // Largest gains and speeds: both clamps, full-range band
    wait_drained();
    write_config('{BASE_W'(16383), GAIN_W'(4095), GAIN_W'(4095), LEVEL_W'(4095),
                   LEVEL_W'(0), LEVEL_W'(4095), MAXS_W'(255)});
    send_frame(frame_t'{FULL, FULL, FULL, FULL, FULL, FULL, FULL});
    send_frame(frame_t'{12'd0, 12'd0, 12'd0, 12'd0, FULL, 12'd0, 12'd0});
    send_frame(frame_t'{FULL, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0});
    send_frame(frame_t'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, FULL});

    // Zero base and ceiling, zero threshold, inverted red band
    wait_drained();
    write_config('{BASE_W'(0), GAIN_W'(4095), GAIN_W'(0), LEVEL_W'(0),
                   LEVEL_W'(4095), LEVEL_W'(0), MAXS_W'(0)});
    send_frame(frame_t'{12'd0, 12'd0, 12'd0, 12'd0, FULL, 12'd0, 12'd0});
    send_frame(frame_t'{FULL, 12'd0, 12'd0, 12'd0, 12'd0, FULL, 12'd0});
    send_frame(frame_t'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0});

    // Random frames under reset values and then random settings
    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      wait_drained();
      if (p == 0) begin
        c = RESET_CFG;
      end else begin
        c.base_speed     = BASE_W'(pick_value(BASE_W));
        c.prop_gain      = GAIN_W'(pick_value(GAIN_W));
        c.deriv_gain     = GAIN_W'(pick_value(GAIN_W));
        c.line_threshold = LEVEL_W'(pick_value(LEVEL_W));
        c.red_low        = LEVEL_W'(pick_value(LEVEL_W));
        c.red_high       = LEVEL_W'(pick_value(LEVEL_W));
        c.max_speed      = MAXS_W'(pick_value(MAXS_W));
      end
      write_config(c);
      // Run one setting at full rate on both sides
      idle_on = (p != 2);
      for (int i = 0; i < FRAMES_PER_SETTING; i++) send_frame(random_frame());
    end
    idle_on = 1'b1;

    // Drain, then let the pipeline settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    $display("Sent %0d sensor frames over %0d register settings, checked %0d results.",
             frames_sent, settings_used, checked);
    $display("Seen: %0d frames with no front signal, %0d results with a clamped drive.",
             no_signal_seen, saturated_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_line_sensor_pd_steering_top passed");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, pending);
      $display("tb_line_sensor_pd_steering_top failed");
    end
    $finish;
  end

endmodule
